>>> hdl/imhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhq_pkg: shared types and constants
// Sizes, operation and status codes, controller-to-datapath command types.
// ----------------------------------------------------------------------------
package imhq_pkg;
    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 16;
    localparam int PAGE_BITS  = 8;
    localparam int SLOT_BITS  = $clog2(CAPACITY + 1);
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int PAGE_COUNT = 1 << PAGE_BITS;
    localparam int ENTRY_BITS = PAGE_BITS + KEY_BITS;

    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_EXTRACT  = 2'd1;
    localparam logic [1:0] KIND_INCREASE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_ABSENT   = 3'd4;
    localparam logic [2:0] ST_DECREASE = 3'd5;

    // Datapath operation selected by the controller each cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,      // capture input fields, position read under way
        OP_LOOKUP,     // capture position, read slot cur or the root
        OP_CHECK,      // capture read entry, read the last slot
        OP_APPEND,     // open a hole at count+1 for the new entry
        OP_SET_KEY,    // load the new key into the cursor entry
        OP_READ_UP,    // read parent of s
        OP_STEP_UP,    // move parent down if smaller
        OP_MOVE_LAST,  // last entry becomes the cursor, drop extracted page
        OP_READ_L,     // read left child
        OP_READ_R,     // read right child
        OP_STEP_DOWN,  // move larger child up if larger than the cursor
        OP_PLACE       // store cursor entry at its final slot
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       done;
        logic [2:0] status;
        logic       key_stored;
        logic       clr_key;
        logic       slot_ok;
        logic       zero_page;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       present;
        logic       full;
        logic       empty;
        logic       decrease;
        logic       up_more;
        logic       up_swap;
        logic       down_more;
        logic       down_swap;
    } t_stat;
endpackage
`default_nettype wire

>>> hdl/indexed_max_heap_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_max_heap_queue: indexed binary max-heap of page identifiers
// Insert, extract-max and key-increase on a 64-entry heap with position table.
// ----------------------------------------------------------------------------
// Usage: raise start with i_kind, i_page_id and i_key; the transaction is
// taken at the rising edge where start is high and busy is low, and the
// fields are captured at that edge. One result follows on o_status,
// o_page_out, o_key_out, o_slot_out and o_count_out, held until the next
// result; o_valid marks it for one cycle. The receiver cannot stall it.
// Insert and key increase sift the entry up level by level, and extract
// sifts the last entry down from the root. o_valid goes high in the same
// cycle that busy falls, and a new transaction may be taken in that same
// cycle. One transaction at a time.
// Reset clears the position valid bits, the entry count and the controller;
// heap memory is left as is, since only slots up to the count are read.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue
    import imhq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_kind,
    input  wire logic [PAGE_BITS-1:0] i_page_id,
    input  wire logic [KEY_BITS-1:0]  i_key,
    output logic                      o_valid,
    output logic [2:0]                o_status,
    output logic [PAGE_BITS-1:0]      o_page_out,
    output logic [KEY_BITS-1:0]       o_key_out,
    output logic [SLOT_BITS-1:0]      o_slot_out,
    output logic [SLOT_BITS-1:0]      o_count_out
);
    t_cmd  w_cmd;
    t_stat w_stat;

    imhq_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    imhq_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_kind(i_kind),
        .i_page_id(i_page_id), .i_key(i_key), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_valid(o_valid), .o_status(o_status), .o_page_out(o_page_out),
        .o_key_out(o_key_out), .o_slot_out(o_slot_out), .o_count_out(o_count_out)
    );
endmodule
`default_nettype wire

>>> hdl/imhq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhq_datapath: heap storage and sift datapath
// Heap memory, position table with valid bits, cursor and result registers.
// ----------------------------------------------------------------------------
module imhq_datapath
    import imhq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [1:0]           i_kind,
    input  wire logic [PAGE_BITS-1:0] i_page_id,
    input  wire logic [KEY_BITS-1:0]  i_key,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    output logic                      o_valid,
    output logic [2:0]                o_status,
    output logic [PAGE_BITS-1:0]      o_page_out,
    output logic [KEY_BITS-1:0]       o_key_out,
    output logic [SLOT_BITS-1:0]      o_slot_out,
    output logic [SLOT_BITS-1:0]      o_count_out
);
    // Heap entries, slot s lives at address s-1.
    logic [ENTRY_BITS-1:0] r_heap [CAPACITY];
    logic [SLOT_BITS-1:0]  r_pos [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_pos_vld;

    logic [1:0]            r_kind;
    logic [PAGE_BITS-1:0]  r_page;
    logic [KEY_BITS-1:0]   r_key;
    logic [SLOT_BITS-1:0]  r_count, r_s, r_cur;
    logic [SLOT_BITS-1:0]  r_pos_rd;
    logic [ENTRY_BITS-1:0] r_a, r_b, r_rd; // cursor entry, left child, read data

    function automatic logic [ADDR_BITS-1:0] addr(input logic [SLOT_BITS-1:0] s);
        logic [SLOT_BITS-1:0] t;
        t = s - 1'b1;
        return t[ADDR_BITS-1:0];
    endfunction

    logic [SLOT_BITS-1:0]  w_par, w_l, w_r, w_pos_now, w_child_slot;
    logic [KEY_BITS-1:0]   w_ka, w_kb, w_kd;
    logic                  w_has_right, w_right_wins;
    logic [ENTRY_BITS-1:0] w_child;
    assign w_par = r_s >> 1;
    assign w_l   = {r_s[SLOT_BITS-2:0], 1'b0};
    assign w_r   = {r_s[SLOT_BITS-2:0], 1'b1};
    assign w_ka  = r_a[KEY_BITS-1:0];
    assign w_kb  = r_b[KEY_BITS-1:0];
    assign w_kd  = r_rd[KEY_BITS-1:0];
    assign w_pos_now    = r_pos_vld[r_page] ? r_pos_rd : '0;
    assign w_has_right  = (w_r <= r_count);
    // Right child is on r_rd during a down step; left wins a tie.
    assign w_right_wins = w_has_right && (w_kd > w_kb);
    assign w_child      = w_right_wins ? r_rd : r_b;
    assign w_child_slot = w_right_wins ? w_r : w_l;

    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.present   = (r_cur != '0) && (r_cur <= r_count);
        o_stat.full      = (r_count >= SLOT_BITS'(CAPACITY));
        o_stat.empty     = (r_count == '0);
        o_stat.decrease  = (r_key < w_kd);
        o_stat.up_more   = (r_s > SLOT_BITS'(1));
        o_stat.up_swap   = (w_kd < w_ka);
        o_stat.down_more = (r_s <= SLOT_BITS'(CAPACITY / 2)) && (w_l <= r_count);
        o_stat.down_swap = (w_ka < w_child[KEY_BITS-1:0]);
    end

    // Heap memory: one write and one read a cycle.
    logic                  w_we;
    logic [ADDR_BITS-1:0]  w_wa, w_ra;
    logic [ENTRY_BITS-1:0] w_wd;
    // Position table: one write a cycle, one read.
    logic                  w_pwe;
    logic [PAGE_BITS-1:0]  w_pwa;
    logic [SLOT_BITS-1:0]  w_pwd;
    logic                  w_pvld;

    always_comb begin
        w_we = 1'b0; w_wa = addr(r_s); w_wd = r_a;
        w_ra = addr(r_s);
        w_pwe = 1'b0; w_pwa = r_page; w_pwd = r_s; w_pvld = 1'b1;
        case (i_cmd.op)
            OP_LOOKUP: begin
                w_ra = (r_kind == KIND_EXTRACT) ? addr(SLOT_BITS'(1)) : addr(w_pos_now);
            end
            OP_CHECK:     w_ra = addr(r_count);
            OP_READ_UP:   w_ra = addr(w_par);
            OP_STEP_UP: begin
                if (o_stat.up_swap) begin
                    w_we = 1'b1; w_wd = r_rd;
                    w_pwe = 1'b1; w_pwa = r_rd[ENTRY_BITS-1:KEY_BITS];
                end
            end
            OP_MOVE_LAST: begin
                // Drop the extracted page from the position table.
                w_pwe = 1'b1; w_pwa = r_a[ENTRY_BITS-1:KEY_BITS];
                w_pwd = '0; w_pvld = 1'b0;
            end
            OP_READ_L:    w_ra = addr(w_l);
            OP_READ_R:    w_ra = addr(w_r);
            OP_STEP_DOWN: begin
                if (o_stat.down_swap) begin
                    w_we = 1'b1; w_wd = w_child;
                    w_pwe = 1'b1; w_pwa = w_child[ENTRY_BITS-1:KEY_BITS];
                end
            end
            OP_PLACE: begin
                // An emptied heap has nothing left to store.
                if (r_count != '0) begin
                    w_we = 1'b1;
                    w_pwe = 1'b1; w_pwa = r_a[ENTRY_BITS-1:KEY_BITS];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_heap[w_wa] <= w_wd;
        r_rd <= r_heap[w_ra];
        if (w_pwe) r_pos[w_pwa] <= w_pwd;
        r_pos_rd <= r_pos[i_page_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_vld <= '0;
            r_count   <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= i_cmd.done;
            if (w_pwe) r_pos_vld[w_pwa] <= w_pvld;
            case (i_cmd.op)
                OP_APPEND:    r_count <= r_count + 1'b1;
                OP_MOVE_LAST: r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_kind <= i_kind; r_page <= i_page_id; r_key <= i_key;
            end
            OP_LOOKUP: begin
                r_cur <= w_pos_now; r_s <= w_pos_now;
            end
            OP_CHECK:  r_a <= r_rd;
            OP_APPEND: begin
                r_s <= r_count + 1'b1; r_a <= {r_page, r_key};
            end
            OP_SET_KEY: r_a <= {r_page, r_key};
            OP_STEP_UP: begin
                if (o_stat.up_swap) r_s <= w_par;
            end
            OP_MOVE_LAST: begin
                // Hold the extracted entry for the result; last entry sifts down.
                r_page <= r_a[ENTRY_BITS-1:KEY_BITS]; r_key <= r_a[KEY_BITS-1:0];
                r_a <= r_rd; r_s <= SLOT_BITS'(1);
            end
            OP_READ_R: r_b <= r_rd;
            OP_STEP_DOWN: begin
                if (o_stat.down_swap) r_s <= w_child_slot;
            end
            default: ;
        endcase
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            o_status    <= i_cmd.status;
            o_page_out  <= i_cmd.zero_page ? '0 : r_page;
            o_key_out   <= i_cmd.clr_key ? '0 : (i_cmd.key_stored ? w_kd : r_key);
            o_slot_out  <= i_cmd.slot_ok ? r_s : '0;
            o_count_out <= r_count;
        end
    end
endmodule
`default_nettype wire

>>> hdl/imhq_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhq_controller: operation sequencer
// Steps the datapath through lookup, checks and the sift loops.
// ----------------------------------------------------------------------------
module imhq_controller
    import imhq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  t_stat     i_stat,
    output t_cmd      o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_CHECK, S_APPEND, S_SET, S_UP_RD, S_UP_STEP,
        S_EX_MOVE, S_DN_L, S_DN_R, S_DN_STEP, S_PLACE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd = '0;
        o_cmd.op = OP_NONE;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LATCH;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.op = OP_LOOKUP;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_state = S_IDLE;
                case (i_stat.kind)
                    KIND_INSERT: begin
                        if (i_stat.present) begin
                            o_cmd.done = 1'b1; o_cmd.status = ST_DUP;
                            o_cmd.key_stored = 1'b1;
                        end else if (i_stat.full) begin
                            o_cmd.done = 1'b1; o_cmd.status = ST_FULL;
                            o_cmd.clr_key = 1'b1;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end
                    KIND_EXTRACT: begin
                        if (i_stat.empty) begin
                            o_cmd.done = 1'b1; o_cmd.status = ST_EMPTY;
                            o_cmd.clr_key = 1'b1; o_cmd.zero_page = 1'b1;
                        end else begin
                            n_state = S_EX_MOVE;
                        end
                    end
                    KIND_INCREASE: begin
                        if (!i_stat.present) begin
                            o_cmd.done = 1'b1; o_cmd.status = ST_ABSENT;
                            o_cmd.clr_key = 1'b1;
                        end else if (i_stat.decrease) begin
                            o_cmd.done = 1'b1; o_cmd.status = ST_DECREASE;
                            o_cmd.key_stored = 1'b1;
                        end else begin
                            n_state = S_SET;
                        end
                    end
                    default: begin
                        // Unused kind: report ok and change nothing.
                        o_cmd.done = 1'b1; o_cmd.status = ST_OK;
                        o_cmd.clr_key = 1'b1;
                    end
                endcase
            end
            S_APPEND: begin
                o_cmd.op = OP_APPEND;
                n_state = S_UP_RD;
            end
            S_SET: begin
                o_cmd.op = OP_SET_KEY;
                n_state = S_UP_RD;
            end
            S_UP_RD: begin
                if (i_stat.up_more) begin
                    o_cmd.op = OP_READ_UP;
                    n_state = S_UP_STEP;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_UP_STEP: begin
                o_cmd.op = OP_STEP_UP;
                n_state = i_stat.up_swap ? S_UP_RD : S_PLACE;
            end
            S_EX_MOVE: begin
                o_cmd.op = OP_MOVE_LAST;
                n_state = S_DN_L;
            end
            S_DN_L: begin
                if (i_stat.down_more) begin
                    o_cmd.op = OP_READ_L;
                    n_state = S_DN_R;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_R: begin
                o_cmd.op = OP_READ_R;
                n_state = S_DN_STEP;
            end
            S_DN_STEP: begin
                o_cmd.op = OP_STEP_DOWN;
                n_state = i_stat.down_swap ? S_DN_L : S_PLACE;
            end
            S_PLACE: begin
                o_cmd.op = OP_PLACE;
                o_cmd.done = 1'b1; o_cmd.status = ST_OK;
                o_cmd.slot_ok = (i_stat.kind != KIND_EXTRACT);
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
    assign busy = (r_state != S_IDLE);
endmodule
`default_nettype wire
